>>> hdl/csv_column_weighted_sum_defines.svh
// assertion macros for the csv column weighted sum modules, used by cws_accum
`ifndef CSV_COLUMN_WEIGHTED_SUM_DEFINES_SVH
`define CSV_COLUMN_WEIGHTED_SUM_DEFINES_SVH

// same-cycle implication, held off during reset
`define CWS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cws assertion failed");

// next-cycle implication, held off during reset
`define CWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cws assertion failed");

`endif

>>> hdl/cws_pkg.sv
// shared types and constants for the csv column weighted sum block
package cws_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 40;
    localparam int unsigned OUT_W             = 40;
    localparam int unsigned VALUE_W           = 16;
    localparam logic [7:0]  COL_SELECT_RESET  = 8'd5;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] WEIGHT_LOW  = 2'd1;
    localparam logic [1:0] WEIGHT_HIGH = 2'd2;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2,
        PH_SPARE  = 2'd3
    } phase_t;

    // record-end event from the parser to the accumulator stage
    typedef struct packed {
        logic                      fire;
        logic signed [VALUE_W-1:0] value;
    } rec_evt_t;

endpackage

>>> hdl/cws_parser.sv
// csv byte parser: quote state, column tracking and atoi-style field conversion
module cws_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        column_select,
    output cws_pkg::rec_evt_t evt
);

    logic                quoted_reg,  quoted_next;
    logic [7:0]          column_reg,  column_next;
    cws_pkg::phase_t     phase_reg,   phase_next;
    logic                neg_reg,     neg_next;
    logic [15:0]         mag_reg,     mag_next;

    logic        is_quote;
    logic        is_comma;
    logic        is_record_end;
    logic        is_space;
    logic        is_digit;
    logic        col_match;
    logic [19:0] mag_prod;
    logic [15:0] mag_clip;

    assign is_quote      = (data_byte == cws_pkg::CH_QUOTE);
    assign is_comma      = !quoted_reg && (data_byte == cws_pkg::CH_COMMA);
    assign is_record_end = !quoted_reg && (data_byte == cws_pkg::CH_NEWLINE);
    assign is_space      = (data_byte == cws_pkg::CH_SPACE)
                        || (data_byte >= cws_pkg::CH_TAB && data_byte <= cws_pkg::CH_CR);
    assign is_digit      = (data_byte >= cws_pkg::CH_ZERO) && (data_byte <= cws_pkg::CH_NINE);
    assign col_match     = (column_select != 8'd0) && (column_reg == column_select);

    // magnitude * 10 + digit, saturating at 16 bits
    assign mag_prod = ({4'd0, mag_reg} * 20'd10) + {16'd0, data_byte[3:0]};
    assign mag_clip = (|mag_prod[19:16]) ? 16'hFFFF : mag_prod[15:0];

    // atoi-style value of the selected column, clamped to 16 bits signed
    always_comb begin
        evt.fire = is_record_end;
        if (neg_reg) begin
            evt.value = (mag_reg > 16'h8000) ? 16'sh8000 : 16'(16'd0 - mag_reg);
        end else begin
            evt.value = (mag_reg > 16'h7FFF) ? 16'sh7FFF : $signed(mag_reg);
        end
    end

    always_comb begin
        quoted_next = quoted_reg;
        column_next = column_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        if (is_record_end) begin
            column_next = 8'd1;
            phase_next  = cws_pkg::PH_SKIP;
            neg_next    = 1'b0;
            mag_next    = 16'd0;
        end else if (is_comma) begin
            // column 0 means past the last column, sticks until record end
            if (column_reg == 8'd255) begin
                column_next = 8'd0;
            end else if (column_reg != 8'd0) begin
                column_next = column_reg + 8'd1;
            end
        end else begin
            if (is_quote) begin
                quoted_next = !quoted_reg;
            end
            if (col_match) begin
                unique case (phase_reg)
                    cws_pkg::PH_SKIP: begin
                        if (!is_space) begin
                            phase_next = cws_pkg::PH_DIGITS;
                            if (data_byte == cws_pkg::CH_MINUS) begin
                                neg_next = 1'b1;
                            end else if (data_byte != cws_pkg::CH_PLUS) begin
                                if (is_digit) begin
                                    mag_next = mag_clip;
                                end else begin
                                    phase_next = cws_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                    cws_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            mag_next = mag_clip;
                        end else begin
                            phase_next = cws_pkg::PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quoted_reg <= 1'b0;
            column_reg <= 8'd1;
            phase_reg  <= cws_pkg::PH_SKIP;
            neg_reg    <= 1'b0;
            mag_reg    <= 16'd0;
        end else if (step) begin
            quoted_reg <= quoted_next;
            column_reg <= column_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
        end
    end

endmodule

>>> hdl/cws_accum.sv
// saturating accumulators and result register
`include "csv_column_weighted_sum_defines.svh"

module cws_accum #(
    parameter int unsigned COUNTER_WIDTH = cws_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   load,
    input  cws_pkg::rec_evt_t                      evt,
    input  logic                                   m_ready,
    output logic                                   m_valid,
    output logic signed [cws_pkg::VALUE_W-1:0]     m_field_value,
    output logic                                   m_value_counted,
    output logic [cws_pkg::OUT_W-1:0]              m_running_sum,
    output logic [cws_pkg::OUT_W-1:0]              m_weighted_count,
    output logic [cws_pkg::OUT_W-1:0]              m_record_total
);

    logic                                valid_reg;
    logic signed [cws_pkg::VALUE_W-1:0]  value_reg;
    logic                                counted_reg;
    logic [COUNTER_WIDTH-1:0]            sum_acc_reg,    sum_acc_next;
    logic [COUNTER_WIDTH-1:0]            count_acc_reg,  count_acc_next;
    logic [COUNTER_WIDTH-1:0]            record_acc_reg, record_acc_next;

    logic                 counted;
    logic [1:0]           weight;
    logic [COUNTER_WIDTH:0] sum_wide;
    logic [COUNTER_WIDTH:0] count_wide;
    logic [COUNTER_WIDTH:0] record_wide;

    // values 1..6 count; 1..4 weigh one, 5..6 weigh two
    assign counted = !evt.value[cws_pkg::VALUE_W-1] && (evt.value != '0)
                  && (evt.value <= 16'sd6);
    assign weight  = (evt.value <= 16'sd4) ? cws_pkg::WEIGHT_LOW : cws_pkg::WEIGHT_HIGH;

    assign sum_wide    = {1'b0, sum_acc_reg} + (COUNTER_WIDTH+1)'(evt.value[2:0]);
    assign count_wide  = {1'b0, count_acc_reg} + (COUNTER_WIDTH+1)'(weight);
    assign record_wide = {1'b0, record_acc_reg} + (COUNTER_WIDTH+1)'(1);

    always_comb begin
        sum_acc_next    = sum_acc_reg;
        count_acc_next  = count_acc_reg;
        if (counted) begin
            sum_acc_next   = sum_wide[COUNTER_WIDTH] ? '1 : sum_wide[COUNTER_WIDTH-1:0];
            count_acc_next = count_wide[COUNTER_WIDTH] ? '1 : count_wide[COUNTER_WIDTH-1:0];
        end
        record_acc_next = record_wide[COUNTER_WIDTH] ? '1 : record_wide[COUNTER_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            sum_acc_reg    <= '0;
            count_acc_reg  <= '0;
            record_acc_reg <= '0;
        end else begin
            if (load) begin
                valid_reg      <= 1'b1;
                sum_acc_reg    <= sum_acc_next;
                count_acc_reg  <= count_acc_next;
                record_acc_reg <= record_acc_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg   <= evt.value;
            counted_reg <= counted;
        end
    end

    assign m_valid         = valid_reg;
    assign m_field_value   = value_reg;
    assign m_value_counted = counted_reg;

    // accumulators only move on a load, so they hold while the result waits
    generate
        if (COUNTER_WIDTH >= cws_pkg::OUT_W) begin : g_trunc
            assign m_running_sum    = sum_acc_reg[cws_pkg::OUT_W-1:0];
            assign m_weighted_count = count_acc_reg[cws_pkg::OUT_W-1:0];
            assign m_record_total   = record_acc_reg[cws_pkg::OUT_W-1:0];
        end else begin : g_ext
            assign m_running_sum    = {{(cws_pkg::OUT_W-COUNTER_WIDTH){1'b0}}, sum_acc_reg};
            assign m_weighted_count = {{(cws_pkg::OUT_W-COUNTER_WIDTH){1'b0}}, count_acc_reg};
            assign m_record_total   = {{(cws_pkg::OUT_W-COUNTER_WIDTH){1'b0}}, record_acc_reg};
        end
    endgenerate

    `CWS_ASSERT_NEXT(a_sum_hold, aclk, aresetn, load && !counted,
        (sum_acc_reg == $past(sum_acc_reg)) && (count_acc_reg == $past(count_acc_reg)))
    `CWS_ASSERT_NEXT(a_record_moves, aclk, aresetn, load,
        valid_reg && (record_acc_reg != '0) && (record_acc_reg >= $past(record_acc_reg)))
    `CWS_ASSERT_NOW(a_counted_range, aclk, aresetn, valid_reg && counted_reg,
        (value_reg >= 16'sd1) && (value_reg <= 16'sd6))

endmodule

>>> hdl/csv_column_weighted_sum.sv
// top level of the csv column weighted sum block
// usage:
//   s_ channel carries one csv text byte per item (s_data_byte)
//   m_ channel gives one result item per record, at each newline outside quotes:
//     field value of the selected column, counted flag, and the three
//     saturating counters (sum, weighted count, record count) after that record
//   cfg channel writes column_select (one-based); cfg_ready is always high,
//     write only while no item is in flight
// order: an accepted byte waits in the input register until the parse stage
//   takes it; a record end loads its result in the same cycle that it is parsed
// throughput: one byte per cycle while no record end waits, set by the
//   single parse stage that updates quote, column and number state per byte
// reset: aresetn low at a clock edge clears parse state and counters and
//   sets column_select to 5; no result item is pending after reset
// stall: while a result waits for m_ready, non-record bytes keep flowing;
//   a record-end byte waits in the input register until the result is taken
module csv_column_weighted_sum #(
    parameter int unsigned COUNTER_WIDTH = cws_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // byte input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cws_pkg::VALUE_W-1:0]  m_field_value,
    output logic                                m_value_counted,
    output logic [cws_pkg::OUT_W-1:0]           m_running_sum,
    output logic [cws_pkg::OUT_W-1:0]           m_weighted_count,
    output logic [cws_pkg::OUT_W-1:0]           m_record_total,
    // column_select write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [7:0]                          cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic [7:0]        col_sel_reg;
    logic              out_free;
    logic              step;
    cws_pkg::rec_evt_t evt;

    // output slot is free when empty or being drained this cycle
    assign out_free  = !m_valid || m_ready;
    // a held byte moves on unless it ends a record and the result slot is busy
    assign step      = in_valid_reg && (!evt.fire || out_free);
    assign s_ready   = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_sel_reg <= cws_pkg::COL_SELECT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            col_sel_reg <= cfg_data;
        end
    end

    // parse stage: quote and column tracking plus field conversion
    cws_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .data_byte     (in_byte_reg),
        .column_select (col_sel_reg),
        .evt           (evt)
    );

    // counters and result register
    cws_accum #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (step && evt.fire),
        .evt              (evt),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_field_value    (m_field_value),
        .m_value_counted  (m_value_counted),
        .m_running_sum    (m_running_sum),
        .m_weighted_count (m_weighted_count),
        .m_record_total   (m_record_total)
    );

endmodule

>>> tb/sv/tb_csv_column_weighted_sum.sv
`timescale 1ns / 100ps
// self-checking testbench for the csv column weighted sum block
module tb_csv_column_weighted_sum;

    // counters in the block are as wide as the result fields here
    localparam int unsigned CTR_W         = cws_pkg::COUNTER_WIDTH_DEF;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // settle time after the last expected result has been taken
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef logic [cws_pkg::OUT_W-1:0]          count_t;
    typedef logic signed [cws_pkg::VALUE_W-1:0] value_t;

    // one expected result item
    typedef struct {
        value_t value;
        logic   counted;
        count_t sum;
        count_t weight;
        count_t records;
    } record_result_t;

    // clock, reset and block ports
    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [7:0]                 s_data_byte = 8'h00;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    value_t                     m_field_value;
    logic                       m_value_counted;
    count_t                     m_running_sum;
    count_t                     m_weighted_count;
    count_t                     m_record_total;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [7:0]                 cfg_data    = 8'h00;

    // parser mirror, starting at its reset values
    logic [7:0]       sel_column    = cws_pkg::COL_SELECT_RESET;
    logic             in_quotes     = 1'b0;
    logic [7:0]       col_pos       = 8'd1;
    cws_pkg::phase_t  num_phase     = cws_pkg::PH_SKIP;
    logic             is_negative   = 1'b0;
    logic [15:0]      mag_value     = 16'd0;
    count_t           total_sum     = '0;
    count_t           total_weight  = '0;
    count_t           total_records = '0;

    record_result_t expected_records[$];

    // run bookkeeping
    int unsigned error_count     = 0;
    int unsigned bytes_sent      = 0;
    int unsigned records_checked = 0;
    int unsigned counted_seen    = 0;
    int unsigned cycle_count     = 0;
    int unsigned src_idle_pct    = 0;
    int unsigned sink_idle_pct   = 0;
    int unsigned hold_request    = 0;
    int unsigned hold_left       = 0;

    // whitespace bytes other than newline, which would end an unquoted record
    logic [7:0] blank_chars [5] = '{cws_pkg::CH_SPACE, cws_pkg::CH_TAB, 8'h0B, 8'h0C,
                                    cws_pkg::CH_CR};

    csv_column_weighted_sum #(
        .COUNTER_WIDTH(CTR_W)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_field_value   (m_field_value),
        .m_value_counted (m_value_counted),
        .m_running_sum   (m_running_sum),
        .m_weighted_count(m_weighted_count),
        .m_record_total  (m_record_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // saturating counter add
    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [cws_pkg::OUT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[cws_pkg::OUT_W] ? '1 : s[cws_pkg::OUT_W-1:0];
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == cws_pkg::CH_SPACE || (c >= cws_pkg::CH_TAB && c <= cws_pkg::CH_CR);
    endfunction

    // atoi-style number pickup, only for bytes of the selected column
    function automatic void column_byte(input logic [7:0] c);
        logic [31:0] grown;
        if (sel_column == 8'd0 || col_pos != sel_column) return;
        if (num_phase == cws_pkg::PH_SKIP) begin
            if (is_blank(c)) return;
            num_phase = cws_pkg::PH_DIGITS;
            if (c == cws_pkg::CH_MINUS) begin
                is_negative = 1'b1;
                return;
            end
            if (c == cws_pkg::CH_PLUS) return;
        end
        if (num_phase == cws_pkg::PH_DIGITS) begin
            if (c >= cws_pkg::CH_ZERO && c <= cws_pkg::CH_NINE) begin
                grown = mag_value * 32'd10 + 32'(c - cws_pkg::CH_ZERO);
                // magnitude sticks at the 16-bit top
                mag_value = (grown > 32'hFFFF) ? 16'hFFFF : grown[15:0];
            end else begin
                num_phase = cws_pkg::PH_DONE;
            end
        end
    endfunction

    // advance the mirror by one taken byte, queue a result at a record end
    function automatic void predict_byte(input logic [7:0] c);
        int             val;
        record_result_t r;
        if (c == cws_pkg::CH_QUOTE) begin
            // a quote flips the quoted state and is still a field byte
            in_quotes = !in_quotes;
            column_byte(c);
            return;
        end
        if (!in_quotes && c == cws_pkg::CH_COMMA) begin
            // past column 255 the position parks at 0 and never matches
            if (col_pos == 8'd255) col_pos = 8'd0;
            else if (col_pos != 8'd0) col_pos = col_pos + 8'd1;
            return;
        end
        if (in_quotes || c != cws_pkg::CH_NEWLINE) begin
            column_byte(c);
            return;
        end
        // record end: clamp to the signed 16-bit range
        if (is_negative) val = (mag_value > 16'd32768) ? -32768 : -int'(mag_value);
        else val = (mag_value > 16'd32767) ? 32767 : int'(mag_value);
        r.counted = (val >= 1 && val <= 6);
        if (r.counted) begin
            total_sum    = sat_add(total_sum, count_t'(val));
            total_weight = sat_add(total_weight,
                                   (val <= 4) ? count_t'(cws_pkg::WEIGHT_LOW)
                                              : count_t'(cws_pkg::WEIGHT_HIGH));
        end
        total_records = sat_add(total_records, count_t'(1));
        r.value   = value_t'(val);
        r.sum     = total_sum;
        r.weight  = total_weight;
        r.records = total_records;
        expected_records.push_back(r);
        col_pos     = 8'd1;
        num_phase   = cws_pkg::PH_SKIP;
        is_negative = 1'b0;
        mag_value   = 16'd0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at record %0d: %s got %0h expected %0h",
                 records_checked, what, got, want);
        error_count++;
    endtask

    // offer one byte, with random gaps ahead of it, and hold it until taken
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic drain_stream();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // column_select is only written with nothing in flight
    task automatic write_column(input logic [7:0] v);
        drain_stream();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sel_column = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one field of random shape: mostly numbers, some quoted, empty or junk
    task automatic send_random_field();
        int kind;
        kind = $urandom_range(9);
        if (kind <= 5) begin
            repeat ($urandom_range(2)) send_byte(blank_chars[3'($urandom_range(4))]);
            case ($urandom_range(3))
                1: send_byte(cws_pkg::CH_MINUS);
                2: send_byte(cws_pkg::CH_PLUS);
                default: ;
            endcase
            // single digits keep most values in the counted window
            if ($urandom_range(3) != 0) begin
                send_byte(8'(cws_pkg::CH_ZERO + $urandom_range(9)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'(cws_pkg::CH_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(3) == 0) send_byte(8'(8'h61 + $urandom_range(25)));
        end else if (kind == 6) begin
            // commas and newlines inside quotes are plain field bytes
            send_byte(cws_pkg::CH_QUOTE);
            repeat ($urandom_range(4)) begin
                case ($urandom_range(3))
                    0: send_byte(cws_pkg::CH_COMMA);
                    1: send_byte(cws_pkg::CH_NEWLINE);
                    2: send_byte(8'(cws_pkg::CH_ZERO + $urandom_range(9)));
                    default: send_byte(8'(8'h41 + $urandom_range(25)));
                endcase
            end
            send_byte(cws_pkg::CH_QUOTE);
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end else if (kind == 9) begin
            repeat ($urandom_range(1, 4)) send_byte(8'(8'h61 + $urandom_range(25)));
        end
    endtask

    // a record of 1 to 7 fields, sometimes after a burst of raw noise
    task automatic send_random_record();
        int nf;
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
        nf = $urandom_range(1, 7);
        for (int f = 0; f < nf; f++) begin
            if (f != 0) send_byte(cws_pkg::CH_COMMA);
            send_random_field();
        end
        // close a dangling quote so the newline ends the record
        if (in_quotes) send_byte(cws_pkg::CH_QUOTE);
        send_byte(cws_pkg::CH_NEWLINE);
    endtask

    // column_select left at its reset value
    task automatic test_reset_column();
        send_text("a,b,c,d, 4,x\n");
        send_text("1,2\n");
    endtask

    // edge values, signs, saturation, quotes and a missing column
    task automatic test_directed_cases();
        write_column(8'd1);
        send_text("1");
        send_byte(8'hFF);
        send_byte(cws_pkg::CH_NEWLINE);
        send_byte(8'h00);
        send_byte(cws_pkg::CH_NEWLINE);
        send_text(" \t+5x\n");
        send_text("\"4\n\"\n");
        send_text("99999\n");
        send_text("-99999\n");
        send_text("\n");
        write_column(8'd2);
        send_text("\"1,2\",3\n");
        send_text("8\n");
    endtask

    task automatic test_random_records(input int unsigned src_pct, input int unsigned sink_pct,
                                       input logic [7:0] column, input int unsigned n_bytes);
        int unsigned stop_at;
        write_column(column);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_record();
    endtask

    // highest column, the column counter parking past 255, and column zero
    task automatic test_column_limits();
        write_column(8'd255);
        // column 255 holds the value, later fields sit past it and never match
        repeat (254) send_byte(cws_pkg::CH_COMMA);
        send_text(" 5,4,,3\n");
        write_column(8'd0);
        send_text("1,2,3,4,5\n");
        send_text("6\n");
    endtask

    // long output stall while short records keep coming, so the input backs up
    task automatic test_back_pressure();
        write_column(8'd1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 150;
        repeat (40) begin
            send_byte(8'(cws_pkg::CH_ZERO + $urandom_range(9)));
            send_byte(cws_pkg::CH_NEWLINE);
        end
    endtask

    // result side ready, random or held off for a counted stretch
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // compare every taken result item with the oldest expectation
    always @(posedge aclk) begin
        record_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                report_mismatch("result item with none expected", 64'd0, 64'd0);
            end else begin
                want = expected_records.pop_front();
                records_checked++;
                if (want.counted) counted_seen++;
                if (m_field_value !== want.value)
                    report_mismatch("field_value", 64'(m_field_value), 64'(want.value));
                if (m_value_counted !== want.counted)
                    report_mismatch("value_counted", 64'(m_value_counted), 64'(want.counted));
                if (m_running_sum !== want.sum)
                    report_mismatch("running_sum", 64'(m_running_sum), 64'(want.sum));
                if (m_weighted_count !== want.weight)
                    report_mismatch("weighted_count", 64'(m_weighted_count), 64'(want.weight));
                if (m_record_total !== want.records)
                    report_mismatch("record_total", 64'(m_record_total), 64'(want.records));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_csv_column_weighted_sum: errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_column();
        test_directed_cases();
        // receiver idles more, then the sender, then neither
        test_random_records(27, 57, 8'd3, 80);
        test_random_records(57, 27, 8'd5, 80);
        test_random_records(0, 0, 8'd2, 80);
        test_column_limits();
        test_back_pressure();
        drain_stream();

        $display("sent %0d bytes, checked %0d records, %0d with counted values",
                 bytes_sent, records_checked, counted_seen);
        $display("columns 5, 1, 2, 3, 255 and 0 under three idling mixes and a long stall");
        if (error_count == 0) begin
            $display("tb_csv_column_weighted_sum: clean");
        end else begin
            $display("tb_csv_column_weighted_sum: errors");
        end
        $finish;
    end

endmodule

>>> csv_column_weighted_sum.f
+incdir+hdl
hdl/cws_pkg.sv
hdl/cws_parser.sv
hdl/cws_accum.sv
hdl/csv_column_weighted_sum.sv
tb/sv/tb_csv_column_weighted_sum.sv
